[src/tkf_pkg.sv]
// Shared types and constants for the two-state temperature Kalman filter.
package tkf_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_INIT    = 2'd0;
  localparam mode_t MODE_UPDATE  = 2'd1;
  localparam mode_t MODE_PREDICT = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -66'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/temp_kalman_filter_2state.sv]
// Two-state temperature Kalman filter built around one shared multiply/add unit.
// Steps from accept to out_valid: init and the unused mode go straight to the result; a
// prediction runs product, three divide-by-1000 digit steps and a final sum; an update
// runs eleven multiply steps plus a restoring divide run once for each gain.
// Throughput: one beat at a time; in_ready returns the cycle after the result is taken.
// Reset (rst_n, synchronous): state zero, covariance identity, step_interval ONE.
module temp_kalman_filter_2state #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tkf_pkg::mode_t      in_mode,
  input  logic signed [31:0]  in_temperature_in,
  input  logic [15:0]         in_elapsed_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_temp_est,
  output logic signed [31:0]  out_slope_est,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_step_interval
);
  import tkf_pkg::*;

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_PRED = 4'd3;
  localparam logic [3:0] ST_OUT  = 4'd4;

  // Multiply program steps of the update.
  localparam logic [3:0] OP_X0M  = 4'd0;
  localparam logic [3:0] OP_A00  = 4'd1;
  localparam logic [3:0] OP_A01  = 4'd2;
  localparam logic [3:0] OP_M00  = 4'd3;
  localparam logic [3:0] OP_M10  = 4'd4;
  localparam logic [3:0] OP_K0   = 4'd5;
  localparam logic [3:0] OP_K1   = 4'd6;
  localparam logic [3:0] OP_TMP  = 4'd7;
  localparam logic [3:0] OP_SLP  = 4'd8;
  localparam logic [3:0] OP_P00  = 4'd9;
  localparam logic [3:0] OP_P01  = 4'd10;
  localparam logic [3:0] OP_P10  = 4'd11;
  localparam logic [3:0] OP_P11  = 4'd12;

  // 2^36 / 1000 rounded up; exact quotients for dividends below 2^26.
  localparam logic [26:0] RECIP_1000 = 27'd68719477;

  logic [3:0]         state_r, state_nxt;
  logic [3:0]         op_r, op_nxt;
  logic [23:0]        dt_r;
  logic signed [31:0] xt_r, xs_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] x0m_r, a00_r, a01_r, m00_r, m10_r, k0_r, k1_r, innov_r;
  logic signed [31:0] meas_r, ot_r, os_r;
  logic [15:0]        ms_r;

  // Divider registers: restoring, one quotient bit per cycle on magnitudes.
  logic [63:0]        dnum_r;
  logic [31:0]        dden_r;
  logic [32:0]        drem_r;
  logic [63:0]        dquo_r;
  logic [6:0]         dcnt_r;
  logic               dneg_r;
  logic               dsel_r;

  // Shared multiply-add unit operands.
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mul_c;
  logic               mul_sub;
  logic signed [65:0] prod, prod_rnd;
  logic signed [31:0] mul_q, mul_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_temp_est  = ot_r;
  assign out_slope_est = os_r;

  // Operand selection for the multiply step in progress.
  always_comb begin
    mul_a = 33'sd0; mul_b = 33'sd0; mul_c = 32'sd0; mul_sub = 1'b0;
    unique case (op_r)
      OP_X0M: begin mul_a = {9'd0, dt_r}; mul_b = 33'(xs_r); mul_c = xt_r; end
      OP_A00: begin mul_a = {9'd0, dt_r}; mul_b = 33'(p10_r); mul_c = p00_r; end
      OP_A01: begin mul_a = {9'd0, dt_r}; mul_b = 33'(p11_r); mul_c = p01_r; end
      OP_M00: begin mul_a = {9'd0, dt_r}; mul_b = 33'(a01_r); mul_c = a00_r; end
      OP_M10: begin mul_a = {9'd0, dt_r}; mul_b = 33'(p11_r); mul_c = p10_r; end
      OP_TMP: begin mul_a = 33'(k0_r); mul_b = 33'(innov_r); mul_c = x0m_r; end
      OP_SLP: begin mul_a = 33'(k1_r); mul_b = 33'(innov_r); mul_c = xs_r; end
      OP_P00: begin mul_a = 33'(sat32(66'(ONE) - 66'(k0_r))); mul_b = 33'(m00_r); end
      OP_P01: begin mul_a = 33'(sat32(66'(ONE) - 66'(k0_r))); mul_b = 33'(a01_r); end
      OP_P10: begin mul_a = 33'(k1_r); mul_b = 33'(m00_r); mul_c = m10_r; mul_sub = 1'b1; end
      OP_P11: begin
        mul_a = 33'(k1_r); mul_b = 33'(a01_r);
        mul_c = sat32(66'(p11_r) + 66'(ONE)); mul_sub = 1'b1;
      end
      default: begin mul_a = 33'sd0; end
    endcase
  end

  assign prod     = 66'(mul_a) * 66'(mul_b);
  assign prod_rnd = (prod + HALF) >>> FRAC_BITS;
  assign mul_q    = sat32(prod_rnd);
  assign mul_res  = mul_sub ? sat32(66'(mul_c) - 66'(mul_q)) : sat32(66'(mul_c) + 66'(mul_q));

  // Mode two extrapolation: ms * slope / 1000 rounded half away from zero.
  // The magnitude plus 500 is divided by 1000 one 16-bit digit per cycle.
  logic signed [49:0] ext_p, ext_mag;
  logic [47:0]        ext_num_r;
  logic [47:0]        ext_quo_r;
  logic [9:0]         ext_rem_r;
  logic               ext_neg_r;
  logic [2:0]         pcnt_r;
  logic [25:0]        dig_n;
  logic [51:0]        dig_prod;
  logic [15:0]        dig_q;
  logic [9:0]         dig_r;
  assign ext_p    = 50'(signed'({1'b0, ms_r})) * 50'(xs_r);
  assign ext_mag  = (ext_p < 0) ? -ext_p : ext_p;
  assign dig_n    = {ext_rem_r, ext_num_r[47:32]};
  assign dig_prod = 52'(dig_n) * 52'(RECIP_1000);
  assign dig_q    = dig_prod[51:36];
  assign dig_r    = 10'(dig_n - 26'(dig_q) * 26'd1000);

  // Divider quotient magnitude to saturated signed gain.
  logic signed [31:0] div_res;
  always_comb begin
    if (dneg_r) begin
      div_res = (dquo_r > 64'h8000_0000) ? S32_MIN : 32'(-$signed(dquo_r));
    end else begin
      div_res = (dquo_r > 64'h7FFF_FFFF) ? S32_MAX : dquo_r[31:0];
    end
  end

  logic signed [31:0] s_val, div_num;
  logic [32:0]        trial;
  assign s_val   = sat32(66'(m00_r) + 66'(ONE));
  assign div_num = dsel_r ? m10_r : m00_r;
  assign trial   = {drem_r[31:0], dnum_r[63]};

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_X0M;
      dt_r    <= 24'(ONE);
      xt_r    <= 32'sd0;
      xs_r    <= 32'sd0;
      p00_r   <= ONE;
      p01_r   <= 32'sd0;
      p10_r   <= 32'sd0;
      p11_r   <= ONE;
      dsel_r  <= 1'b0;
      dcnt_r  <= 7'd0;
      pcnt_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cfg_valid && cfg_ready) begin
        dt_r <= cfg_step_interval;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r <= in_temperature_in;
            ms_r   <= in_elapsed_ms;
            if (in_mode == MODE_INIT) begin
              xt_r <= in_temperature_in; xs_r <= 32'sd0;
              p00_r <= ONE; p01_r <= 32'sd0; p10_r <= 32'sd0; p11_r <= ONE;
              ot_r <= in_temperature_in; os_r <= 32'sd0;
            end else begin
              ot_r <= xt_r;
              os_r <= xs_r;
            end
          end
        end
        ST_PRED: begin
          if (pcnt_r == 3'd0) begin
            // Register the product magnitude with half the divisor added.
            ext_num_r <= 48'(ext_mag) + 48'd500;
            ext_neg_r <= (ext_p < 0);
            ext_rem_r <= 10'd0;
            ext_quo_r <= 48'd0;
            pcnt_r    <= 3'd1;
          end else if (pcnt_r <= 3'd3) begin
            ext_num_r <= {ext_num_r[31:0], 16'd0};
            ext_rem_r <= dig_r;
            ext_quo_r <= {ext_quo_r[31:0], dig_q};
            pcnt_r    <= pcnt_r + 3'd1;
          end else begin
            ot_r <= sat32(66'(xt_r) + (ext_neg_r ? -66'(signed'({1'b0, ext_quo_r}))
                                                 : 66'(signed'({1'b0, ext_quo_r}))));
            pcnt_r <= 3'd0;
          end
        end
        ST_MUL: begin
          unique case (op_r)
            OP_X0M: begin
              x0m_r   <= mul_res;
              innov_r <= sat32(66'(meas_r) - 66'(mul_res));
            end
            OP_A00: a00_r <= mul_res;
            OP_A01: a01_r <= mul_res;
            OP_M00: m00_r <= sat32(66'(mul_res) + 66'(ONE));
            OP_M10: begin
              m10_r  <= mul_res;
              dsel_r <= 1'b0;
              dcnt_r <= 7'd0;
            end
            OP_TMP: xt_r <= mul_res;
            OP_SLP: begin xs_r <= mul_res; os_r <= mul_res; end
            OP_P00: p00_r <= mul_res;
            OP_P01: p01_r <= mul_res;
            OP_P10: p10_r <= mul_res;
            OP_P11: p11_r <= mul_res;
            default: ot_r <= ot_r;
          endcase
          if (op_r == OP_TMP) ot_r <= mul_res;
        end
        ST_DIV: begin
          if (dcnt_r == 7'd0) begin
            // Load magnitudes of numerator * ONE and divisor.
            dnum_r <= 64'(div_num[31] ? -66'(div_num) : 66'(div_num)) << FRAC_BITS;
            dden_r <= s_val[31] ? 32'(-33'(s_val)) : s_val;
            dneg_r <= div_num[31] ^ s_val[31];
            drem_r <= 33'd0;
            dquo_r <= 64'd0;
            dcnt_r <= 7'd1;
          end else if (dcnt_r <= 7'd64) begin
            dnum_r <= {dnum_r[62:0], 1'b0};
            if (trial >= {1'b0, dden_r}) begin
              drem_r <= trial - {1'b0, dden_r};
              dquo_r <= {dquo_r[62:0], 1'b1};
            end else begin
              drem_r <= trial;
              dquo_r <= {dquo_r[62:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 7'd1;
          end else begin
            // Finished: zero divisor saturates by numerator sign.
            if (s_val == 32'sd0) begin
              if (dsel_r) k1_r <= (m10_r > 0) ? S32_MAX : ((m10_r < 0) ? S32_MIN : 32'sd0);
              else        k0_r <= (m00_r > 0) ? S32_MAX : ((m00_r < 0) ? S32_MIN : 32'sd0);
            end else begin
              if (dsel_r) k1_r <= div_res;
              else        k0_r <= div_res;
            end
            dsel_r <= 1'b1;
            dcnt_r <= 7'd0;
          end
        end
        ST_OUT: begin
          dcnt_r <= 7'd0;
        end
        default: dcnt_r <= 7'd0;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = OP_X0M;
          if (in_mode == MODE_UPDATE)       state_nxt = ST_MUL;
          else if (in_mode == MODE_PREDICT) state_nxt = ST_PRED;
          else                              state_nxt = ST_OUT;
        end
      end
      ST_PRED: if (pcnt_r == 3'd4) state_nxt = ST_OUT;
      ST_MUL: begin
        if (op_r == OP_M10) begin
          state_nxt = ST_DIV; op_nxt = OP_K0;
        end else if (op_r == OP_P11) begin
          state_nxt = ST_OUT;
        end else begin
          op_nxt = op_r + 4'd1;
        end
      end
      ST_DIV: begin
        if (dcnt_r == 7'd65 && dsel_r) begin
          state_nxt = ST_MUL; op_nxt = OP_TMP;
        end
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/tkf_checker.sv]
// Port-level checker for the temperature Kalman filter, bound to the top level.
module tkf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_temp_est,
  input logic        cfg_ready
);
  // The block never takes a new beat while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // An accepted beat drops ready on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready held after accept");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_temp_est)))
    else $error("result changed while stalled");

  // Configuration is only open when the input side is idle.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == in_ready) else $error("config port open while busy");
endmodule

bind temp_kalman_filter_2state tkf_checker u_tkf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_temp_est(out_temp_est),
  .cfg_ready(cfg_ready)
);

[test/tb_temp_kalman_filter_2state.sv]
// Self-checking testbench for the two-state temperature Kalman filter.
module tb_temp_kalman_filter_2state;
  import tkf_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int N_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 3000000;

  // Saturating fixed-point helpers used by the filter predictor.
  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int qadd(input int a, input int b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(input int a, input int b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  function automatic int qmul(input longint a, input longint b);
    longint p;
    p = a * b + (ONE >>> 1);
    return clip32(p >>> FRAC);
  endfunction

  function automatic int qdiv(input int num, input int den);
    if (den == 0) begin
      if (num > 0) return 32'h7FFF_FFFF;
      if (num < 0) return 32'h8000_0000;
      return 0;
    end
    return clip32((longint'(num) * ONE) / longint'(den));
  endfunction

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] slope;
  } estimate_t;

  // Holds the filter state and the queue of estimates still to arrive.
  class estimate_board;
    int t_est, s_est;
    int p00, p01, p10, p11;
    longint dt;
    estimate_t pending[$];
    int errors;
    int checked;

    function void clear();
      t_est = 0; s_est = 0;
      p00 = int'(ONE); p01 = 0; p10 = 0; p11 = int'(ONE);
      dt = ONE;
      errors = 0;
      checked = 0;
    endfunction

    function void set_step(input logic [23:0] v);
      dt = longint'(v);
    endfunction

    // Run the filter on one accepted input beat.
    function void note_input(input mode_t mode, input int meas, input logic [15:0] ms);
      int x0m, a00, a01, m00, m01, m10, m11, s, k0, k1, innov, omk;
      longint p, q;
      estimate_t e;
      e.temp = t_est;
      e.slope = s_est;
      case (mode)
        MODE_INIT: begin
          t_est = meas; s_est = 0;
          p00 = int'(ONE); p01 = 0; p10 = 0; p11 = int'(ONE);
          e.temp = meas; e.slope = 0;
        end
        MODE_UPDATE: begin
          x0m = qadd(t_est, qmul(dt, s_est));
          a00 = qadd(p00, qmul(dt, p10));
          a01 = qadd(p01, qmul(dt, p11));
          m00 = qadd(qadd(a00, qmul(a01, dt)), int'(ONE));
          m01 = a01;
          m10 = qadd(p10, qmul(p11, dt));
          m11 = qadd(p11, int'(ONE));
          s = qadd(m00, int'(ONE));
          k0 = qdiv(m00, s);
          k1 = qdiv(m10, s);
          innov = qsub(meas, x0m);
          omk = qsub(int'(ONE), k0);
          t_est = qadd(x0m, qmul(k0, innov));
          s_est = qadd(s_est, qmul(k1, innov));
          p00 = qmul(omk, m00);
          p01 = qmul(omk, m01);
          p10 = qsub(m10, qmul(k1, m00));
          p11 = qsub(m11, qmul(k1, m01));
          e.temp = t_est; e.slope = s_est;
        end
        MODE_PREDICT: begin
          p = longint'(ms) * longint'(s_est);
          q = (p >= 0) ? (p + 500) / 1000 : (p - 500) / 1000;
          e.temp = clip32(longint'(t_est) + q);
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(input logic signed [31:0] t, input logic signed [31:0] s);
      estimate_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result temp=%0d slope=%0d", $time, t, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (t !== e.temp) begin
        $display("%0t: temp_est expected %0d actual %0d", $time, e.temp, t);
        errors++;
      end
      if (s !== e.slope) begin
        $display("%0t: slope_est expected %0d actual %0d", $time, e.slope, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mode_t in_mode = MODE_INIT;
  logic signed [31:0] in_temperature_in = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_temp_est, out_slope_est;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_step_interval = '0;

  estimate_board board = new();
  longint cycles = 0;
  bit sink_on = 1'b0;
  int cfg_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  temp_kalman_filter_2state u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_temperature_in(in_temperature_in), .in_elapsed_ms(in_elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temp_est(out_temp_est), .out_slope_est(out_slope_est),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_step_interval(cfg_step_interval)
  );

  // Pick an idle length: mostly none or short, occasionally long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result side: accept beats with random back-pressure and check each one.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_temp_kalman_filter_2state: FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready) board.check_result(out_temp_est, out_slope_est);
  end

  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (!sink_on) begin
        out_ready <= 1'b0;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Send one input beat and record it once accepted.
  task automatic send_beat(input mode_t m, input logic signed [31:0] t, input logic [15:0] ms);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_temperature_in <= t;
    in_elapsed_ms <= ms;
    do @(posedge clk); while (!in_ready);
    board.note_input(m, t, ms);
  endtask

  // Write step_interval once the block has drained.
  task automatic write_step(input logic [23:0] v);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_step_interval <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_step(v);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  function automatic logic [31:0] rand_temp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($urandom_range(0, 100)) << FRAC;
    endcase
  endfunction

  initial begin
    logic [23:0] steps[6];
    logic [31:0] base;
    mode_t m;
    int r;
    steps = '{24'h010000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h008000, 24'h040000};
    base = 32'd0;
    board.clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    sink_on = 1'b1;

    // Directed beats: field extremes, every mode and the unused mode code.
    send_beat(MODE_PREDICT, 0, 16'hFFFF);
    send_beat(MODE_UPDATE, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_UPDATE, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_PREDICT, 0, 16'hFFFF);
    send_beat(mode_t'(2'd3), 32'sh1234_5678, 16'h5555);
    send_beat(MODE_INIT, 32'sh8000_0000, 16'hFFFF);
    send_beat(MODE_UPDATE, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_PREDICT, 0, 16'd1);
    send_beat(MODE_INIT, 32'sh7FFF_FFFF, 0);
    send_beat(MODE_UPDATE, 32'sh8000_0000, 16'hAAAA);
    send_beat(MODE_PREDICT, 32'hFFFF_FFFF, 16'd500);
    send_beat(MODE_INIT, 32'sh0014_0000, 0);
    repeat (5) send_beat(MODE_UPDATE, 32'sh0015_0000, 0);
    send_beat(MODE_PREDICT, 0, 16'd1500);
    // A huge step drives the covariance towards saturation.
    write_step(24'hFFFFFF);
    repeat (6) send_beat(MODE_UPDATE, 32'sh8000_0000, 16'hFFFF);
    send_beat(MODE_PREDICT, 0, 16'hFFFF);

    // Random phases: occasional inits followed by runs of updates along a ramp, plus predictions.
    for (int ph = 0; ph < 12; ph++) begin
      write_step(steps[ph % 6]);
      for (int i = 0; i < N_RANDOM / 12; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          base = rand_temp();
          send_beat(MODE_INIT, base, 16'($urandom()));
        end else if (r < 80) begin
          base = base + 32'($urandom_range(0, 4096)) - 32'd2048;
          send_beat(MODE_UPDATE, ($urandom_range(0, 9) == 0) ? rand_temp() : base,
                    16'($urandom()));
        end else if (r < 97) begin
          send_beat(MODE_PREDICT, rand_temp(), 16'($urandom()));
        end else begin
          send_beat(mode_t'(2'd3), rand_temp(), 16'($urandom()));
        end
      end
    end

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d estimates over %0d step_interval writes, all modes and saturation.",
             board.checked, cfg_count);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_temp_kalman_filter_2state: PASS");
    end else begin
      $display("tb_temp_kalman_filter_2state: FAIL");
    end
    $finish;
  end

endmodule
